>>> rtl/stok_pkg.sv
// Shared types and constants for the s-expression tokenizer.
// Used by the front queue, the scanner back end, the top level and the checker.
package stok_pkg;

  localparam int PositionBitsDefault = 32;
  localparam int LengthBitsDefault   = 16;

  // Queue depths; both must be powers of two so the pointers wrap on their own.
  localparam int QueueDepth = 4;
  localparam int OutDepth   = 4;

  localparam int TextBits   = 8;
  localparam int StartBits  = 32;
  localparam int LenOutBits = 16;
  localparam int PrefixBits = 48;
  localparam int KeyMaxLen  = 6;

  localparam logic [PrefixBits-1:0] KwDefine = 48'h646566696E65;
  localparam logic [PrefixBits-1:0] KwLoop   = 48'h00006C6F6F70;
  localparam logic [PrefixBits-1:0] KwIf     = 48'h000000006966;
  localparam logic [PrefixBits-1:0] KwCond   = 48'h0000636F6E64;

  localparam logic [TextBits-1:0] ChNewline    = 8'h0A;
  localparam logic [TextBits-1:0] ChUnderscore = 8'h5F;
  localparam logic [TextBits-1:0] ChDot        = 8'h2E;
  localparam logic [TextBits-1:0] ChSemi       = 8'h3B;

  typedef enum logic [3:0] {
    CLS_SPACE,
    CLS_NEWLINE,
    CLS_SEMI,
    CLS_LPAREN,
    CLS_RPAREN,
    CLS_LBRACK,
    CLS_RBRACK,
    CLS_OP,
    CLS_WORD_START,
    CLS_DIGIT,
    CLS_DOT,
    CLS_OTHER
  } char_class_t;

  typedef enum logic [3:0] {
    KIND_INT    = 4'd0,
    KIND_FLOAT  = 4'd1,
    KIND_OP     = 4'd2,
    KIND_IDENT  = 4'd3,
    KIND_DEFINE = 4'd4,
    KIND_LOOP   = 4'd5,
    KIND_IF     = 4'd6,
    KIND_COND   = 4'd7,
    KIND_LPAREN = 4'd8,
    KIND_RPAREN = 4'd9,
    KIND_LBRACK = 4'd10,
    KIND_RBRACK = 4'd11,
    KIND_END    = 4'd12,
    KIND_ERROR  = 4'd13
  } kind_t;

  typedef enum logic [5:0] {
    MODE_IDLE    = 6'b000001,
    MODE_SEMI    = 6'b000010,
    MODE_COMMENT = 6'b000100,
    MODE_IDENT   = 6'b001000,
    MODE_NUMBER  = 6'b010000,
    MODE_HALT    = 6'b100000
  } mode_t;

  typedef struct packed {
    logic [TextBits-1:0] text;
    logic                end_flag;
    char_class_t         cls;
  } queue_item_t;

  typedef struct packed {
    logic        valid;
    queue_item_t item;
  } queue_head_t;

  typedef struct packed {
    kind_t                 kind;
    logic [StartBits-1:0]  start;
    logic [LenOutBits-1:0] length;
    logic [TextBits-1:0]   ch;
    logic                  last;
  } token_t;

endpackage

>>> rtl/stok_front.sv
// Front end of the tokenizer: accepts input beats, classifies each byte
// and holds the classified items in a short queue. Depends on stok_pkg.
module stok_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,   // [7:0] text_byte
  input  logic                       s_tlast,   // end_of_text
  output stok_pkg::queue_head_t      head,
  input  logic                       pop
);

  localparam int PtrBits = $clog2(stok_pkg::QueueDepth);
  localparam int CntBits = $clog2(stok_pkg::QueueDepth + 1);

  stok_pkg::queue_item_t entries [stok_pkg::QueueDepth];
  logic [PtrBits-1:0] wr_ptr;
  logic [PtrBits-1:0] rd_ptr;
  logic [CntBits-1:0] count;
  logic               push;
  logic               take;
  stok_pkg::queue_item_t new_item;

  function automatic stok_pkg::char_class_t classify(input logic [7:0] c);
    stok_pkg::char_class_t cls;
    if (c == stok_pkg::ChNewline) begin
      cls = stok_pkg::CLS_NEWLINE;
    end else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
      cls = stok_pkg::CLS_SPACE;
    end else if (c == stok_pkg::ChSemi) begin
      cls = stok_pkg::CLS_SEMI;
    end else if (c == 8'h28) begin
      cls = stok_pkg::CLS_LPAREN;
    end else if (c == 8'h29) begin
      cls = stok_pkg::CLS_RPAREN;
    end else if (c == 8'h5B) begin
      cls = stok_pkg::CLS_LBRACK;
    end else if (c == 8'h5D) begin
      cls = stok_pkg::CLS_RBRACK;
    end else if (c == 8'h2B || c == 8'h2D || c == 8'h2A || c == 8'h2F ||
                 c == 8'h3C || c == 8'h3E || c == 8'h3D) begin
      cls = stok_pkg::CLS_OP;
    end else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
                 c == stok_pkg::ChUnderscore) begin
      cls = stok_pkg::CLS_WORD_START;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      cls = stok_pkg::CLS_DIGIT;
    end else if (c == stok_pkg::ChDot) begin
      cls = stok_pkg::CLS_DOT;
    end else begin
      cls = stok_pkg::CLS_OTHER;
    end
    return cls;
  endfunction

  assign s_tready = (count != CntBits'(stok_pkg::QueueDepth));
  assign push     = s_tvalid && s_tready;
  assign take     = head.valid && pop;

  assign new_item.text     = s_tdata;
  assign new_item.end_flag = s_tlast;
  assign new_item.cls      = classify(s_tdata);

  assign head.valid = (count != '0);
  assign head.item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PtrBits'(1);
      end
      if (take) begin
        rd_ptr <= rd_ptr + PtrBits'(1);
      end
      if (push && !take) begin
        count <= count + CntBits'(1);
      end else if (take && !push) begin
        count <= count - CntBits'(1);
      end
    end
  end

endmodule

>>> rtl/stok_back.sv
// Back end of the tokenizer: runs the scan state machine on queued items
// and places up to two tokens per item in an output queue. Depends on stok_pkg.
module stok_back #(
  parameter int POSITION_BITS = stok_pkg::PositionBitsDefault,
  parameter int LENGTH_BITS   = stok_pkg::LengthBitsDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  stok_pkg::queue_head_t head,
  output logic                  pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [55:0]           m_tdata,   // [31:0] token_start, [47:32] token_length,
                                           // [55:48] token_char
  output logic [3:0]            m_tuser,   // [3:0] token_kind
  output logic                  m_tlast    // last_result
);

  localparam int PB      = POSITION_BITS;
  localparam int LB      = LENGTH_BITS;
  localparam int PxB     = stok_pkg::PrefixBits;
  localparam int PtrBits = $clog2(stok_pkg::OutDepth);
  localparam int CntBits = $clog2(stok_pkg::OutDepth + 1);
  localparam logic [LB-1:0] LenMax = '1;

  // Scan state.
  stok_pkg::mode_t mode, mode_next;
  logic [PB-1:0]   pos, pos_next;
  logic [PB-1:0]   open_start, start_next;
  logic [LB-1:0]   open_len, len_next;
  logic [PxB-1:0]  prefix, prefix_next;
  logic            dot_seen, dot_next;

  // Output queue.
  stok_pkg::token_t out_q [stok_pkg::OutDepth];
  logic [PtrBits-1:0] owr_ptr;
  logic [PtrBits-1:0] ord_ptr;
  logic [CntBits-1:0] ocount;

  stok_pkg::queue_item_t item;
  stok_pkg::token_t      tok_a, tok_b, slot0, slot1, out_head;
  logic                  a_valid, b_valid, run_idle;
  logic [1:0]            n_push;
  logic                  opop;
  stok_pkg::kind_t       close_kind;

  assign item = head.item;

  // Room for two tokens is required before an item is taken.
  assign pop  = head.valid && (ocount <= CntBits'(stok_pkg::OutDepth - 2));
  assign opop = m_tvalid && m_tready;

  always_comb begin
    if (mode == stok_pkg::MODE_NUMBER) begin
      close_kind = dot_seen ? stok_pkg::KIND_FLOAT : stok_pkg::KIND_INT;
    end else if (open_len == LB'(6) && prefix == stok_pkg::KwDefine) begin
      close_kind = stok_pkg::KIND_DEFINE;
    end else if (open_len == LB'(4) && prefix == stok_pkg::KwLoop) begin
      close_kind = stok_pkg::KIND_LOOP;
    end else if (open_len == LB'(2) && prefix == stok_pkg::KwIf) begin
      close_kind = stok_pkg::KIND_IF;
    end else if (open_len == LB'(4) && prefix == stok_pkg::KwCond) begin
      close_kind = stok_pkg::KIND_COND;
    end else begin
      close_kind = stok_pkg::KIND_IDENT;
    end
  end

  always_comb begin
    mode_next   = mode;
    pos_next    = pos;
    start_next  = open_start;
    len_next    = open_len;
    prefix_next = prefix;
    dot_next    = dot_seen;
    a_valid     = 1'b0;
    b_valid     = 1'b0;
    run_idle    = 1'b0;

    // The closing token of an open identifier or number.
    tok_a.kind   = close_kind;
    tok_a.start  = stok_pkg::StartBits'(open_start);
    tok_a.length = stok_pkg::LenOutBits'(open_len);
    tok_a.ch     = '0;
    tok_a.last   = 1'b0;

    // Single-character tokens at the current offset by default.
    tok_b.kind   = stok_pkg::KIND_ERROR;
    tok_b.start  = stok_pkg::StartBits'(pos);
    tok_b.length = stok_pkg::LenOutBits'(1);
    tok_b.ch     = item.text;
    tok_b.last   = 1'b0;

    if (mode != stok_pkg::MODE_HALT) begin
      if (item.end_flag) begin
        b_valid = 1'b1;
        if (mode == stok_pkg::MODE_SEMI) begin
          tok_b.kind  = stok_pkg::KIND_ERROR;
          tok_b.start = stok_pkg::StartBits'(open_start);
          tok_b.ch    = stok_pkg::ChSemi;
          mode_next   = stok_pkg::MODE_HALT;
        end else begin
          a_valid      = (mode == stok_pkg::MODE_IDENT) || (mode == stok_pkg::MODE_NUMBER);
          tok_b.kind   = stok_pkg::KIND_END;
          tok_b.length = '0;
          tok_b.ch     = '0;
          mode_next    = stok_pkg::MODE_IDLE;
        end
      end else begin
        pos_next = pos + PB'(1);
        case (mode)
          stok_pkg::MODE_SEMI: begin
            mode_next = (item.cls == stok_pkg::CLS_NEWLINE) ?
                        stok_pkg::MODE_IDLE : stok_pkg::MODE_COMMENT;
          end
          stok_pkg::MODE_COMMENT: begin
            if (item.cls == stok_pkg::CLS_NEWLINE) begin
              mode_next = stok_pkg::MODE_IDLE;
            end
          end
          stok_pkg::MODE_IDENT: begin
            if (item.cls == stok_pkg::CLS_WORD_START || item.cls == stok_pkg::CLS_DIGIT) begin
              // Only the first six characters can still match a keyword.
              if (open_len < LB'(stok_pkg::KeyMaxLen)) begin
                prefix_next = {prefix[PxB-9:0], item.text};
              end
              if (open_len != LenMax) begin
                len_next = open_len + LB'(1);
              end
            end else begin
              a_valid  = 1'b1;
              run_idle = 1'b1;
            end
          end
          stok_pkg::MODE_NUMBER: begin
            if (item.cls == stok_pkg::CLS_DIGIT || item.cls == stok_pkg::CLS_DOT) begin
              if (item.cls == stok_pkg::CLS_DOT) begin
                dot_next = 1'b1;
              end
              if (open_len != LenMax) begin
                len_next = open_len + LB'(1);
              end
            end else begin
              a_valid  = 1'b1;
              run_idle = 1'b1;
            end
          end
          default: begin
            run_idle = 1'b1;
          end
        endcase

        // A closed token hands the same character to the idle scan.
        if (run_idle) begin
          mode_next = stok_pkg::MODE_IDLE;
          case (item.cls)
            stok_pkg::CLS_SPACE, stok_pkg::CLS_NEWLINE: begin
              mode_next = stok_pkg::MODE_IDLE;
            end
            stok_pkg::CLS_SEMI: begin
              mode_next  = stok_pkg::MODE_SEMI;
              start_next = pos;
            end
            stok_pkg::CLS_LPAREN: begin
              b_valid    = 1'b1;
              tok_b.kind = stok_pkg::KIND_LPAREN;
            end
            stok_pkg::CLS_RPAREN: begin
              b_valid    = 1'b1;
              tok_b.kind = stok_pkg::KIND_RPAREN;
            end
            stok_pkg::CLS_LBRACK: begin
              b_valid    = 1'b1;
              tok_b.kind = stok_pkg::KIND_LBRACK;
            end
            stok_pkg::CLS_RBRACK: begin
              b_valid    = 1'b1;
              tok_b.kind = stok_pkg::KIND_RBRACK;
            end
            stok_pkg::CLS_OP: begin
              b_valid    = 1'b1;
              tok_b.kind = stok_pkg::KIND_OP;
            end
            stok_pkg::CLS_WORD_START: begin
              mode_next   = stok_pkg::MODE_IDENT;
              start_next  = pos;
              len_next    = LB'(1);
              prefix_next = PxB'(item.text);
            end
            stok_pkg::CLS_DIGIT, stok_pkg::CLS_DOT: begin
              mode_next  = stok_pkg::MODE_NUMBER;
              start_next = pos;
              len_next   = LB'(1);
              dot_next   = (item.cls == stok_pkg::CLS_DOT);
            end
            default: begin
              b_valid    = 1'b1;
              tok_b.kind = stok_pkg::KIND_ERROR;
              mode_next  = stok_pkg::MODE_HALT;
            end
          endcase
        end
      end
    end
  end

  // Pack the tokens of this item into slots and mark the last one.
  always_comb begin
    if (a_valid) begin
      slot0 = tok_a;
      slot1 = tok_b;
    end else begin
      slot0 = tok_b;
      slot1 = tok_a;
    end
    slot0.last = !(a_valid && b_valid);
    slot1.last = 1'b1;
    n_push     = pop ? ({1'b0, a_valid} + {1'b0, b_valid}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= stok_pkg::MODE_IDLE;
      pos        <= '0;
      open_start <= '0;
      open_len   <= '0;
      prefix     <= '0;
      dot_seen   <= 1'b0;
    end else if (pop) begin
      mode       <= mode_next;
      pos        <= pos_next;
      open_start <= start_next;
      open_len   <= len_next;
      prefix     <= prefix_next;
      dot_seen   <= dot_next;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      out_q[owr_ptr] <= slot0;
    end
    if (n_push == 2'd2) begin
      out_q[owr_ptr + PtrBits'(1)] <= slot1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owr_ptr <= '0;
      ord_ptr <= '0;
      ocount  <= '0;
    end else begin
      owr_ptr <= owr_ptr + PtrBits'(n_push);
      if (opop) begin
        ord_ptr <= ord_ptr + PtrBits'(1);
      end
      ocount <= ocount + CntBits'(n_push) - CntBits'(opop);
    end
  end

  assign out_head = out_q[ord_ptr];
  assign m_tvalid = (ocount != '0);
  assign m_tdata  = {out_head.ch, out_head.length, out_head.start};
  assign m_tuser  = out_head.kind;
  assign m_tlast  = out_head.last;

endmodule

>>> rtl/s_expression_tokenizer.sv
// S-expression tokenizer top level: front classifier queue plus scanner back end.
// A byte's tokens pass through the front queue and then the output queue.
// Throughput: one byte per cycle while the output queue has room; a byte that closes
// a token and emits its own gives two; they leave in turn on the one output port.
// Reset: synchronous, clears both queues and the scan state; no clearing pass.
// Depends on stok_pkg, stok_front and stok_back.
module s_expression_tokenizer #(
  parameter int POSITION_BITS = stok_pkg::PositionBitsDefault,
  parameter int LENGTH_BITS   = stok_pkg::LengthBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  input  logic        s_tlast,   // end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [31:0] token_start, [47:32] token_length,
                                 // [55:48] token_char
  output logic [3:0]  m_tuser,   // [3:0] token_kind
  output logic        m_tlast    // last_result
);

  stok_pkg::queue_head_t head;
  logic                  pop;

  stok_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .head     (head),
    .pop      (pop)
  );

  stok_back #(
    .POSITION_BITS (POSITION_BITS),
    .LENGTH_BITS   (LENGTH_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

>>> rtl/stok_checker.sv
// Port-level checks for the s-expression tokenizer output stream.
// Depends on stok_pkg; bound to s_expression_tokenizer at the end of this file.
module stok_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic [3:0]  m_tuser,
  input logic        m_tlast
);

  // A token beat offered and not taken stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output beat dropped before it was taken");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output beat offered right after reset");

  // The end token is empty and always closes the results of its beat.
  a_end_token: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == stok_pkg::KIND_END |-> m_tdata[47:32] == '0 && m_tlast)
    else $error("end token with length or not last");

  // An error token may carry a zero byte; the other single-character kinds never do.
  a_single_char: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == stok_pkg::KIND_OP || m_tuser == stok_pkg::KIND_LPAREN ||
                 m_tuser == stok_pkg::KIND_RPAREN || m_tuser == stok_pkg::KIND_LBRACK ||
                 m_tuser == stok_pkg::KIND_RBRACK || m_tuser == stok_pkg::KIND_ERROR)
    |-> m_tdata[47:32] == 16'd1 &&
        (m_tdata[55:48] != '0 || m_tuser == stok_pkg::KIND_ERROR))
    else $error("single-character token with wrong length or character");

  a_error_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == stok_pkg::KIND_ERROR |-> m_tlast)
    else $error("error token not the last result of its beat");

endmodule

bind s_expression_tokenizer stok_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
